### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define GSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hdl/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg
// Types and codes shared by the stencil solver controller and datapath.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 23;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [11:0]        cell_index;
        logic signed [23:0] noise_sample;
    } t_in_item;

    typedef struct packed {
        logic [16:0] density;
        logic [12:0] sweeps_used;
        logic        converged;
        logic [23:0] last_change;
    } t_out_item;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_SOLVE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        CFG_COEF_UP     = 3'd0,
        CFG_COEF_DOWN   = 3'd1,
        CFG_COEF_RIGHT  = 3'd2,
        CFG_COEF_LEFT   = 3'd3,
        CFG_NOISE_MIX   = 3'd4,
        CFG_GRID_WIDTH  = 3'd5,
        CFG_GRID_HEIGHT = 3'd6,
        CFG_TOLERANCE   = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        NB_UP    = 2'd0,
        NB_LEFT  = 2'd1,
        NB_RIGHT = 2'd2,
        NB_DOWN  = 2'd3
    } t_nbr;

    typedef enum logic [3:0] {
        OP_NONE        = 4'd0,
        OP_SUM_CLR     = 4'd1,
        OP_NMUL        = 4'd2,
        OP_NACC        = 4'd3,
        OP_CLAT        = 4'd4,
        OP_M1          = 4'd5,
        OP_M2          = 4'd6,
        OP_M3          = 4'd7,
        OP_WB          = 4'd8,
        OP_SWEEP_START = 4'd9,
        OP_OUT_READ    = 4'd10,
        OP_OUT_SOLVE   = 4'd11
    } t_dp_op;

    typedef struct packed {
        t_dp_op      op;
        t_nbr        nbr;
        logic        nbr_present;
        logic        cell_we;
        logic        cell_wzero;
        logic        noise_we;
        logic        read_oob;
        logic        converged;
        logic [12:0] sweeps;
    } t_dp_cmd;

    typedef struct packed {
        logic       out_free;
        logic       sweep_conv;
        logic [6:0] grid_width;
        logic [6:0] grid_height;
    } t_dp_sts;

endpackage

### hdl/gss_ram.sv
// ----------------------------------------------------------------------------
// gss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/gss_ctrl.sv
// ----------------------------------------------------------------------------
// gss_ctrl
// Sequencer: request decode, clear passes, per-cell stencil steps, sweep loop.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gss_ctrl #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int MAX_SWEEPS  = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  gss_pkg::t_in_item                     i_in,
    output logic                                  o_in_ready,
    input  gss_pkg::t_dp_sts                      i_sts,
    output gss_pkg::t_dp_cmd                      o_cmd,
    output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0] o_cell_waddr,
    output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0] o_cell_raddr,
    output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0] o_noise_addr
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int SW    = $clog2(MAX_SWEEPS + 1);

    typedef enum logic [15:0] {
        S_INIT   = 16'h0001,
        S_IDLE   = 16'h0002,
        S_RDWAIT = 16'h0004,
        S_RDOUT  = 16'h0008,
        S_CLR    = 16'h0010,
        S_NADDR  = 16'h0020,
        S_NMUL   = 16'h0040,
        S_NACC   = 16'h0080,
        S_CADDR  = 16'h0100,
        S_CLAT   = 16'h0200,
        S_M1     = 16'h0400,
        S_M2     = 16'h0800,
        S_M3     = 16'h1000,
        S_WB     = 16'h2000,
        S_CHK    = 16'h4000,
        S_SOUT   = 16'h8000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_idx, n_idx;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    gss_pkg::t_nbr   r_nbr, n_nbr;
    logic [SW-1:0]   r_sweeps, n_sweeps;
    logic            r_conv, n_conv;
    logic [AW-1:0]   r_ridx, n_ridx;
    logic            r_roob, n_roob;

    logic [CW-1:0]   eff_cols;
    logic [RW-1:0]   eff_rows;
    logic            col_last, row_last, in_range, nbr_present;
    logic [AW-1:0]   nbr_addr;
    logic [SW-1:0]   sweeps_inc;

    // effective grid size: zero acts as one, oversize acts as the maximum
    always_comb begin
        if (i_sts.grid_width == 7'd0) begin
            eff_cols = CW'(1);
        end else if (32'(i_sts.grid_width) > 32'(MAX_COLUMNS)) begin
            eff_cols = CW'(MAX_COLUMNS);
        end else begin
            eff_cols = CW'(i_sts.grid_width);
        end
        if (i_sts.grid_height == 7'd0) begin
            eff_rows = RW'(1);
        end else if (32'(i_sts.grid_height) > 32'(MAX_ROWS)) begin
            eff_rows = RW'(MAX_ROWS);
        end else begin
            eff_rows = RW'(i_sts.grid_height);
        end
    end

    assign col_last   = (CW'(r_col + 1'b1) == eff_cols);
    assign row_last   = (RW'(r_row + 1'b1) == eff_rows);
    assign in_range   = (32'(i_in.cell_index) < 32'(DEPTH));
    assign sweeps_inc = SW'(r_sweeps + 1'b1);

    always_comb begin
        case (r_nbr)
            gss_pkg::NB_UP: begin
                nbr_present = (r_row != '0);
                nbr_addr    = AW'(r_idx - AW'(eff_cols));
            end
            gss_pkg::NB_LEFT: begin
                nbr_present = (r_col != '0);
                nbr_addr    = AW'(r_idx - 1'b1);
            end
            gss_pkg::NB_RIGHT: begin
                nbr_present = !col_last;
                nbr_addr    = AW'(r_idx + 1'b1);
            end
            default: begin
                nbr_present = !row_last;
                nbr_addr    = AW'(r_idx + AW'(eff_cols));
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_row        = r_row;
        n_col        = r_col;
        n_nbr        = r_nbr;
        n_sweeps     = r_sweeps;
        n_conv       = r_conv;
        n_ridx       = r_ridx;
        n_roob       = r_roob;
        o_cmd        = '0;
        o_cmd.op     = gss_pkg::OP_NONE;
        o_cmd.nbr    = r_nbr;
        o_cell_raddr = r_idx;
        o_noise_addr = r_idx;
        o_in_ready   = 1'b0;

        unique case (r_state)
            S_INIT: begin
                o_cmd.cell_we    = 1'b1;
                o_cmd.cell_wzero = 1'b1;
                n_idx            = AW'(r_idx + 1'b1);
                if (r_idx == AW'(DEPTH - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_noise_addr = AW'(i_in.cell_index);
                if (i_in_valid) begin
                    case (gss_pkg::t_req'(i_in.req_type))
                        gss_pkg::REQ_LOAD: begin
                            o_cmd.noise_we = in_range;
                        end
                        gss_pkg::REQ_SOLVE: begin
                            n_idx   = '0;
                            n_row   = '0;
                            n_col   = '0;
                            n_state = S_CLR;
                        end
                        gss_pkg::REQ_READ: begin
                            n_ridx  = AW'(i_in.cell_index);
                            n_roob  = !in_range;
                            n_state = S_RDWAIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDWAIT: begin
                o_cell_raddr = r_ridx;
                n_state      = S_RDOUT;
            end
            S_RDOUT: begin
                o_cell_raddr = r_ridx;
                if (i_sts.out_free) begin
                    o_cmd.op       = gss_pkg::OP_OUT_READ;
                    o_cmd.read_oob = r_roob;
                    n_state        = S_IDLE;
                end
            end
            S_CLR: begin
                o_cmd.cell_we    = 1'b1;
                o_cmd.cell_wzero = 1'b1;
                n_idx            = AW'(r_idx + 1'b1);
                if (col_last) begin
                    n_col = '0;
                    n_row = RW'(r_row + 1'b1);
                end else begin
                    n_col = CW'(r_col + 1'b1);
                end
                if (col_last && row_last) begin
                    n_idx    = '0;
                    n_row    = '0;
                    n_col    = '0;
                    n_nbr    = gss_pkg::NB_UP;
                    n_sweeps = '0;
                    o_cmd.op = gss_pkg::OP_SWEEP_START;
                    n_state  = S_NADDR;
                end
            end
            S_NADDR: begin
                o_cell_raddr = nbr_addr;
                if (r_nbr == gss_pkg::NB_UP) begin
                    o_cmd.op = gss_pkg::OP_SUM_CLR;
                end
                n_state = S_NMUL;
            end
            S_NMUL: begin
                o_cmd.op          = gss_pkg::OP_NMUL;
                o_cmd.nbr_present = nbr_present;
                n_state           = S_NACC;
            end
            S_NACC: begin
                o_cmd.op = gss_pkg::OP_NACC;
                if (r_nbr == gss_pkg::NB_DOWN) begin
                    n_nbr   = gss_pkg::NB_UP;
                    n_state = S_CADDR;
                end else begin
                    n_nbr   = gss_pkg::t_nbr'(r_nbr + 2'd1);
                    n_state = S_NADDR;
                end
            end
            S_CADDR: begin
                n_state = S_CLAT;
            end
            S_CLAT: begin
                o_cmd.op = gss_pkg::OP_CLAT;
                n_state  = S_M1;
            end
            S_M1: begin
                o_cmd.op = gss_pkg::OP_M1;
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = gss_pkg::OP_M2;
                n_state  = S_M3;
            end
            S_M3: begin
                o_cmd.op = gss_pkg::OP_M3;
                n_state  = S_WB;
            end
            S_WB: begin
                o_cmd.op      = gss_pkg::OP_WB;
                o_cmd.cell_we = 1'b1;
                n_idx         = AW'(r_idx + 1'b1);
                n_state       = S_NADDR;
                if (col_last) begin
                    n_col = '0;
                    n_row = RW'(r_row + 1'b1);
                end else begin
                    n_col = CW'(r_col + 1'b1);
                end
                if (col_last && row_last) begin
                    n_idx   = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_sweeps = sweeps_inc;
                if (i_sts.sweep_conv) begin
                    n_conv  = 1'b1;
                    n_state = S_SOUT;
                end else if (sweeps_inc == SW'(MAX_SWEEPS)) begin
                    n_conv  = 1'b0;
                    n_state = S_SOUT;
                end else begin
                    o_cmd.op = gss_pkg::OP_SWEEP_START;
                    n_state  = S_NADDR;
                end
            end
            S_SOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op        = gss_pkg::OP_OUT_SOLVE;
                    o_cmd.sweeps    = 13'(r_sweeps);
                    o_cmd.converged = r_conv;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cell_waddr = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_idx    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_nbr    <= gss_pkg::NB_UP;
            r_sweeps <= '0;
            r_conv   <= 1'b0;
            r_ridx   <= '0;
            r_roob   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_row    <= n_row;
            r_col    <= n_col;
            r_nbr    <= n_nbr;
            r_sweeps <= n_sweeps;
            r_conv   <= n_conv;
            r_ridx   <= n_ridx;
            r_roob   <= n_roob;
        end
    end

    `GSS_ASSERT_IMP(a_out_load_free, i_clk, i_rst_n, (o_cmd.op == gss_pkg::OP_OUT_READ) || (o_cmd.op == gss_pkg::OP_OUT_SOLVE), i_sts.out_free)
    `GSS_ASSERT_IMP(a_sweep_bound, i_clk, i_rst_n, 1'b1, 32'(r_sweeps) <= 32'(MAX_SWEEPS))
    `GSS_ASSERT_NEXT(a_wb_follow, i_clk, i_rst_n, r_state == S_WB, (r_state == S_NADDR) || (r_state == S_CHK))

endmodule

### hdl/gss_dp.sv
// ----------------------------------------------------------------------------
// gss_dp
// Datapath: config registers, cell and noise stores, shared multiplier,
// stencil accumulation, rounding, change tracking and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gss_dp #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    input  logic [gss_pkg::CFG_AW-1:0]              i_cfg_index,
    input  logic [gss_pkg::CFG_DW-1:0]              i_cfg_data,
    input  gss_pkg::t_in_item                       i_in,
    input  gss_pkg::t_dp_cmd                        i_cmd,
    input  logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0] i_cell_waddr,
    input  logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0] i_cell_raddr,
    input  logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0] i_noise_addr,
    output gss_pkg::t_dp_sts                        o_sts,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output gss_pkg::t_out_item                      o_out
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;

    logic signed [15:0] r_coef_up, r_coef_down, r_coef_right, r_coef_left;
    logic [16:0]        r_noise_mix;
    logic [6:0]         r_grid_width, r_grid_height;
    logic [22:0]        r_tol;

    logic signed [41:0] r_sum;
    logic signed [42:0] r_prod;
    logic signed [60:0] r_mix;
    logic signed [23:0] r_old;
    logic [23:0]        r_maxd;
    gss_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic signed [23:0] cell_rd, noise_rd, nv;
    logic [23:0]        cell_wd;
    logic [16:0]        alpha, beta;
    logic signed [15:0] coef_sel;
    logic signed [17:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [42:0] mul_p;
    logic signed [30:0] nv_full;
    logic signed [24:0] diff, dens;
    logic [24:0]        absd;
    logic [16:0]        dens_clamped;
    logic               out_free;

    gss_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cell_we),
        .i_waddr (i_cell_waddr),
        .i_wdata (cell_wd),
        .i_raddr (i_cell_raddr),
        .o_rdata (cell_rd)
    );

    gss_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_noise_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.noise_we),
        .i_waddr (i_noise_addr),
        .i_wdata (i_in.noise_sample),
        .i_raddr (i_noise_addr),
        .o_rdata (noise_rd)
    );

    // alpha above one saturates to one
    assign alpha = (r_noise_mix > 17'd65536) ? 17'd65536 : r_noise_mix;
    assign beta  = 17'(17'd65536 - alpha);

    always_comb begin
        case (i_cmd.nbr)
            gss_pkg::NB_UP:    coef_sel = r_coef_up;
            gss_pkg::NB_LEFT:  coef_sel = r_coef_left;
            gss_pkg::NB_RIGHT: coef_sel = r_coef_right;
            default:           coef_sel = r_coef_down;
        endcase
    end

    // one shared 18x25 multiplier; wide beta*sum is split at bit 21
    always_comb begin
        case (i_cmd.op)
            gss_pkg::OP_NMUL: begin
                mul_a = {{2{coef_sel[15]}}, coef_sel};
                mul_b = i_cmd.nbr_present ? {cell_rd[23], cell_rd} : '0;
            end
            gss_pkg::OP_CLAT: begin
                mul_a = {1'b0, alpha};
                mul_b = {noise_rd[23], noise_rd};
            end
            gss_pkg::OP_M1: begin
                mul_a = {1'b0, beta};
                mul_b = {4'b0, r_sum[20:0]};
            end
            gss_pkg::OP_M2: begin
                mul_a = {1'b0, beta};
                mul_b = {{4{r_sum[41]}}, r_sum[41:21]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // round the Q.46 sum to the nearest Q.16 (ties up), then saturate to 24 bits
    assign nv_full = r_mix[60:30];
    always_comb begin
        if (nv_full > 31'sd8388607) begin
            nv = 24'sh7fffff;
        end else if (nv_full < -31'sd8388608) begin
            nv = 24'sh800000;
        end else begin
            nv = nv_full[23:0];
        end
    end

    assign diff    = {nv[23], nv} - {r_old[23], r_old};
    assign absd    = diff[24] ? 25'(-diff) : 25'(diff);
    assign cell_wd = i_cmd.cell_wzero ? 24'd0 : nv;

    assign dens = {cell_rd[23], cell_rd} + 25'sd32768;
    always_comb begin
        if (dens < 25'sd0) begin
            dens_clamped = 17'd0;
        end else if (dens > 25'sd65536) begin
            dens_clamped = 17'd65536;
        end else begin
            dens_clamped = dens[16:0];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_up     <= '0;
            r_coef_down   <= '0;
            r_coef_right  <= '0;
            r_coef_left   <= '0;
            r_noise_mix   <= '0;
            r_grid_width  <= 7'd64;
            r_grid_height <= 7'd64;
            r_tol         <= '0;
        end else if (i_cfg_valid) begin
            unique case (gss_pkg::t_cfg_reg'(i_cfg_index))
                gss_pkg::CFG_COEF_UP:     r_coef_up     <= i_cfg_data[15:0];
                gss_pkg::CFG_COEF_DOWN:   r_coef_down   <= i_cfg_data[15:0];
                gss_pkg::CFG_COEF_RIGHT:  r_coef_right  <= i_cfg_data[15:0];
                gss_pkg::CFG_COEF_LEFT:   r_coef_left   <= i_cfg_data[15:0];
                gss_pkg::CFG_NOISE_MIX:   r_noise_mix   <= i_cfg_data[16:0];
                gss_pkg::CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[6:0];
                gss_pkg::CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[6:0];
                gss_pkg::CFG_TOLERANCE:   r_tol         <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (i_cmd.op)
            gss_pkg::OP_SUM_CLR: r_sum <= '0;
            gss_pkg::OP_NACC:    r_sum <= r_sum + r_prod[41:0];
            gss_pkg::OP_CLAT:    r_old <= cell_rd;
            gss_pkg::OP_M1:      r_mix <= {{4{r_prod[42]}}, r_prod, 14'b0} + 61'sd536870912;
            gss_pkg::OP_M2:      r_mix <= r_mix + {{18{r_prod[42]}}, r_prod};
            gss_pkg::OP_M3:      r_mix <= r_mix + {r_prod[39:0], 21'b0};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxd      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == gss_pkg::OP_SWEEP_START) begin
                r_maxd <= '0;
            end else if (i_cmd.op == gss_pkg::OP_WB && absd[23:0] > r_maxd) begin
                r_maxd <= absd[23:0];
            end
            if (i_cmd.op == gss_pkg::OP_OUT_READ || i_cmd.op == gss_pkg::OP_OUT_SOLVE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == gss_pkg::OP_OUT_READ) begin
            r_out.density     <= i_cmd.read_oob ? 17'd0 : dens_clamped;
            r_out.sweeps_used <= '0;
            r_out.converged   <= 1'b0;
            r_out.last_change <= '0;
        end else if (i_cmd.op == gss_pkg::OP_OUT_SOLVE) begin
            r_out.density     <= '0;
            r_out.sweeps_used <= i_cmd.sweeps;
            r_out.converged   <= i_cmd.converged;
            r_out.last_change <= r_maxd;
        end
    end

    assign o_sts.out_free    = out_free;
    assign o_sts.sweep_conv  = ({1'b0, r_tol} >= r_maxd);
    assign o_sts.grid_width  = r_grid_width;
    assign o_sts.grid_height = r_grid_height;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

    `GSS_ASSERT_IMP(a_density_range, i_clk, i_rst_n, r_out_valid, r_out.density <= 17'd65536)
    `GSS_ASSERT_IMP(a_conv_tol, i_clk, i_rst_n, r_out_valid && r_out.converged, r_out.last_change <= {1'b0, r_tol})

endmodule

### hdl/gauss_seidel_stencil_solver_unit.sv
// ----------------------------------------------------------------------------
// gauss_seidel_stencil_solver_unit
// Five-point Gauss-Seidel solver over a Q8.16 grid with noise blend.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------
//  in       | input     | i_in_valid / o_in_ready  | i_in  (load, solve, read)
//  out      | output    | o_out_valid / i_out_ready| o_out (read or solve result)
//  cfg      | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  After reset a clearing pass zeroes the cell store, during which no request
//  is taken (config writes are). A load writes the noise store as it is taken;
//  a read goes through the RDWAIT and RDOUT states to its result.
//  A solve clears the cells in use, then sweeps them: the single cell-store
//  read port and the shared multiplier make each cell a sequence of four
//  neighbor reads and products, center read, three blend steps, write-back.
//  One request at a time; a request is taken while a result still waits in
//  the output register, and a new result stalls until that slot frees.
// ----------------------------------------------------------------------------
module gauss_seidel_stencil_solver_unit #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int MAX_SWEEPS  = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  gss_pkg::t_in_item          i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output gss_pkg::t_out_item         o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [gss_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [gss_pkg::CFG_DW-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_COLUMNS * MAX_ROWS);

    gss_pkg::t_dp_cmd cmd;
    gss_pkg::t_dp_sts sts;
    logic [AW-1:0]    cell_waddr, cell_raddr, noise_addr;

    // config registers are always writable
    assign o_cfg_ready = 1'b1;

    gss_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .MAX_SWEEPS  (MAX_SWEEPS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in         (i_in),
        .o_in_ready   (o_in_ready),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_cell_waddr (cell_waddr),
        .o_cell_raddr (cell_raddr),
        .o_noise_addr (noise_addr)
    );

    gss_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in         (i_in),
        .i_cmd        (cmd),
        .i_cell_waddr (cell_waddr),
        .i_cell_raddr (cell_raddr),
        .i_noise_addr (noise_addr),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

endmodule
